[sv/seeded_random_jitter_vector_top_defines.svh]
// ---------------------------------------------------------------------------
// Seeded random jitter vector assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SEEDED_RANDOM_JITTER_VECTOR_TOP_DEFINES_SVH
`define SEEDED_RANDOM_JITTER_VECTOR_TOP_DEFINES_SVH

// same-cycle implication
`define SRJV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRJV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/srjv_pkg.sv]
// ---------------------------------------------------------------------------
// Seeded random jitter vector package
// Hash constants, pipeline shapes and step functions.
// ---------------------------------------------------------------------------
package srjv_pkg;

  localparam int FRAC_BITS_DEF = 31;

  localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_C1 = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_C2 = 64'h94D049BB133111EB;
  localparam logic [63:0] LANE_KEY [4] = '{
    64'h1111111111111111, 64'h2222222222222222,
    64'h3333333333333333, 64'h4444444444444444
  };
  // 1e-12 at 62 fraction bits
  localparam logic [63:0] DEGEN_LIMIT = 64'd4611687;

  localparam int SQ_STEPS    = 4;
  localparam int SQ_STAGES   = 32 / SQ_STEPS;
  localparam int DIV_STEPS   = 4;
  localparam int DIV_STAGES  = 32 / DIV_STEPS;

  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
  } pp_t;

  typedef struct packed {
    logic [63:0] t;
    logic [31:0] root;
    logic [33:0] rem;
  } sqrt_t;

  typedef struct packed {
    logic [32:0] tr;
    logic [31:0] q;
  } div_t;

  typedef struct packed {
    logic [2:0][31:0]   a;
    logic [2:0]         aneg;
    logic signed [31:0] m;
    logic [31:0]        mmag;
    logic               degen;
  } carry_t;

  function automatic logic [63:0] xorshift(input logic [63:0] z, input int unsigned k);
    return z ^ (z >> k);
  endfunction

  // low 64 bits of a 64x64 product as three 32x32 partial products
  function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
    pp_t p;
    p.ll = 64'(a[31:0]) * 64'(b[31:0]);
    p.lh = 32'(a[31:0] * b[63:32]);
    p.hl = 32'(a[63:32] * b[31:0]);
    return p;
  endfunction

  function automatic logic [63:0] mul_sum(input pp_t p);
    logic [31:0] hi;
    hi = p.lh + p.hl;
    return p.ll + {hi, 32'd0};
  endfunction

  function automatic sqrt_t sqrt_step(input sqrt_t s);
    logic [35:0] trial;
    logic [35:0] cand;
    sqrt_t       o;
    trial = {s.rem, s.t[63:62]};
    cand  = {2'b00, s.root, 2'b01};
    o.t   = {s.t[61:0], 2'b00};
    if (trial >= cand) begin
      o.rem  = 34'(trial - cand);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = trial[33:0];
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic div_t div_step(input div_t d, input logic [31:0] len);
    logic        ge;
    logic [32:0] r;
    div_t        o;
    ge   = d.tr >= {1'b0, len};
    r    = ge ? (d.tr - {1'b0, len}) : d.tr;
    o.tr = {r[31:0], 1'b0};
    o.q  = {d.q[30:0], ge};
    return o;
  endfunction

endpackage

[sv/srjv_in_if.sv]
// ---------------------------------------------------------------------------
// Seeded random jitter vector input channel
// Valid/ready channel carrying one vertex index per word.
// ---------------------------------------------------------------------------
interface srjv_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] vertex_index;

  modport source(output valid, output vertex_index, input ready);
  modport sink(input valid, input vertex_index, output ready);
endinterface

[sv/srjv_out_if.sv]
// ---------------------------------------------------------------------------
// Seeded random jitter vector result channel
// Valid/ready channel carrying one jitter vector per word.
// ---------------------------------------------------------------------------
interface srjv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] jitter_x;
  logic signed [31:0] jitter_y;
  logic signed [31:0] jitter_z;
  logic signed [31:0] normal_scalar;
  logic               degenerate;

  modport source(output valid, output jitter_x, output jitter_y, output jitter_z,
                 output normal_scalar, output degenerate, input ready);
  modport sink(input valid, input jitter_x, input jitter_y, input jitter_z,
               input normal_scalar, input degenerate, output ready);
endinterface

[sv/seeded_random_jitter_vector_top.sv]
// ---------------------------------------------------------------------------
// Seeded random jitter vector
// Per-vertex splitmix64 jitter direction and magnitude in Q1.31.
// ---------------------------------------------------------------------------
// One vertex index enters and one jitter word leaves per cycle while the output
// is not stalled. The pipeline has five stages per splitmix64 round (two 64-bit
// multiplies as 32x32 partials), three for squared length, three for
// normalization, eight for the square root and eight for the three divides
// (four result bits per stage), then three for scaling, rounding and the
// normal scalar. A stall at the output freezes the whole pipeline. The seed
// may be written only while the block is idle.
`include "seeded_random_jitter_vector_top_defines.svh"

module seeded_random_jitter_vector_top #(
  parameter int FRAC_BITS = srjv_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  srjv_in_if.sink     in_ch,
  srjv_out_if.source  out_ch
);

  localparam int SQS = srjv_pkg::SQ_STAGES;
  localparam int DVS = srjv_pkg::DIV_STAGES;
  localparam int ST_N3      = 15;
  localparam int ST_SQ_END  = ST_N3 + SQS;
  localparam int ST_DIV_END = ST_SQ_END + DVS;
  localparam int NST        = ST_DIV_END + 4;
  localparam int ZB = (FRAC_BITS < 31) ? (31 - FRAC_BITS) : 0;
  localparam logic [31:0] VMASK = ~32'((64'd1 << ZB) - 64'd1);

  logic [31:0]    seed_r;
  logic [NST-1:0] v_r;
  logic           en;

  logic [63:0]        b1_r;
  srjv_pkg::pp_t      b2_r;
  logic [63:0]        b3_r;
  srjv_pkg::pp_t      b4_r;
  logic [63:0]        base_r;
  logic [63:0]        h1_r [4];
  srjv_pkg::pp_t      h2_r [4];
  logic [63:0]        h3_r [4];
  srjv_pkg::pp_t      h4_r [4];
  logic [63:0]        hash_r [4];

  srjv_pkg::carry_t   c_q1_r, c_q2_r, c_q3_r, c_n1_r, c_n2_r, c_m1_r, c_m2_r;
  srjv_pkg::carry_t   q1_nxt, q3_nxt, n3_nxt;
  logic [63:0]        sqr_r [3];
  logic [63:0]        sq_r;
  logic [63:0]        t1_r, t2_r, t1_nxt, t2_nxt;
  logic [4:0]         s1_r, s2_r, s1_nxt, s2_nxt;

  srjv_pkg::carry_t   car_r [SQS+DVS+1];
  srjv_pkg::sqrt_t    sqs_r [SQS+1];
  srjv_pkg::div_t     dvs_r [1:DVS][3];
  logic [31:0]        len_r [1:DVS-1];

  logic [63:0]        prod_r [3];
  logic signed [31:0] j_r [3];
  logic signed [31:0] j_nxt [3];
  logic signed [31:0] jx_r, jy_r, jz_r, ns_r, ns_nxt;
  logic               dg_r;

  assign en          = !v_r[NST-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_we) begin
      seed_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_ch.valid};
    end
  end

  // splitmix64 rounds: base hash, then four keyed lanes
  always_ff @(posedge clk) begin
    if (en) begin
      b1_r   <= srjv_pkg::xorshift(({seed_r, 32'd0} ^ {32'd0, in_ch.vertex_index})
                                   + srjv_pkg::GOLDEN, 30);
      b2_r   <= srjv_pkg::mul_pp(b1_r, srjv_pkg::MIX_C1);
      b3_r   <= srjv_pkg::xorshift(srjv_pkg::mul_sum(b2_r), 27);
      b4_r   <= srjv_pkg::mul_pp(b3_r, srjv_pkg::MIX_C2);
      base_r <= srjv_pkg::xorshift(srjv_pkg::mul_sum(b4_r), 31);
      for (int i = 0; i < 4; i++) begin
        h1_r[i]   <= srjv_pkg::xorshift((base_r ^ srjv_pkg::LANE_KEY[i])
                                        + srjv_pkg::GOLDEN, 30);
        h2_r[i]   <= srjv_pkg::mul_pp(h1_r[i], srjv_pkg::MIX_C1);
        h3_r[i]   <= srjv_pkg::xorshift(srjv_pkg::mul_sum(h2_r[i]), 27);
        h4_r[i]   <= srjv_pkg::mul_pp(h3_r[i], srjv_pkg::MIX_C2);
        hash_r[i] <= srjv_pkg::xorshift(srjv_pkg::mul_sum(h4_r[i]), 31);
      end
    end
  end

  // hash to Q1.31: value = top word - 2^31
  always_comb begin
    logic [31:0] vv;
    q1_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      vv             = hash_r[i][63:32] & VMASK;
      q1_nxt.aneg[i] = ~vv[31];
      q1_nxt.a[i]    = vv[31] ? {1'b0, vv[30:0]} : (32'h80000000 - vv);
    end
    vv          = hash_r[3][63:32] & VMASK;
    q1_nxt.m    = {~vv[31], vv[30:0]};
    q1_nxt.mmag = vv[31] ? {1'b0, vv[30:0]} : (32'h80000000 - vv);
  end

  always_comb begin
    q3_nxt       = c_q2_r;
    q3_nxt.degen = (sqr_r[0] + sqr_r[1] + sqr_r[2]) < srjv_pkg::DEGEN_LIMIT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_q1_r <= q1_nxt;
      c_q2_r <= c_q1_r;
      for (int i = 0; i < 3; i++) begin
        sqr_r[i] <= 64'(c_q1_r.a[i]) * 64'(c_q1_r.a[i]);
      end
      sq_r   <= sqr_r[0] + sqr_r[1] + sqr_r[2];
      c_q3_r <= q3_nxt;
    end
  end

  // normalize: smallest even shift reaching 2^62, at most 31 pairs
  always_comb begin
    t1_nxt = sq_r;
    s1_nxt = '0;
    if (t1_nxt[63:30] == '0) begin
      t1_nxt = {t1_nxt[31:0], 32'd0};
      s1_nxt = s1_nxt + 5'd16;
    end
    if (t1_nxt[63:46] == '0) begin
      t1_nxt = {t1_nxt[47:0], 16'd0};
      s1_nxt = s1_nxt + 5'd8;
    end
    if (t1_nxt[63:54] == '0) begin
      t1_nxt = {t1_nxt[55:0], 8'd0};
      s1_nxt = s1_nxt + 5'd4;
    end
  end

  always_comb begin
    t2_nxt = t1_r;
    s2_nxt = s1_r;
    if (t2_nxt[63:58] == '0) begin
      t2_nxt = {t2_nxt[59:0], 4'd0};
      s2_nxt = s2_nxt + 5'd2;
    end
    if (t2_nxt[63:60] == '0) begin
      t2_nxt = {t2_nxt[61:0], 2'd0};
      s2_nxt = s2_nxt + 5'd1;
    end
    if (t2_nxt[63:62] == '0 && s2_nxt != 5'd31) begin
      t2_nxt = {t2_nxt[61:0], 2'd0};
      s2_nxt = s2_nxt + 5'd1;
    end
  end

  always_comb begin
    n3_nxt = c_n2_r;
    for (int i = 0; i < 3; i++) begin
      n3_nxt.a[i] = 32'({32'd0, c_n2_r.a[i]} << s2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r     <= t1_nxt;
      s1_r     <= s1_nxt;
      c_n1_r   <= c_q3_r;
      t2_r     <= t2_nxt;
      s2_r     <= s2_nxt;
      c_n2_r   <= c_n1_r;
      sqs_r[0] <= '{t: t2_r, root: '0, rem: '0};
      car_r[0] <= n3_nxt;
    end
  end

  for (genvar g = 1; g <= SQS; g++) begin : g_sqrt
    srjv_pkg::sqrt_t st;
    always_comb begin
      st = sqs_r[g-1];
      for (int k = 0; k < srjv_pkg::SQ_STEPS; k++) begin
        st = srjv_pkg::sqrt_step(st);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sqs_r[g] <= st;
        car_r[g] <= car_r[g-1];
      end
    end
  end

  for (genvar g = 1; g <= DVS; g++) begin : g_div
    srjv_pkg::div_t din [3];
    srjv_pkg::div_t dst [3];
    logic [31:0]    dlen;
    if (g == 1) begin : g_first
      assign dlen = sqs_r[SQS].root;
      for (genvar i = 0; i < 3; i++) begin : g_init
        assign din[i].tr = {1'b0, car_r[SQS].a[i]};
        assign din[i].q  = '0;
      end
    end else begin : g_rest
      assign dlen = len_r[g-1];
      assign din  = dvs_r[g-1];
    end
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        dst[i] = din[i];
        for (int k = 0; k < srjv_pkg::DIV_STEPS; k++) begin
          dst[i] = srjv_pkg::div_step(dst[i], dlen);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dvs_r[g]     <= dst;
        car_r[SQS+g] <= car_r[SQS+g-1];
      end
    end
    if (g < DVS) begin : g_len
      always_ff @(posedge clk) begin
        if (en) begin
          len_r[g] <= dlen;
        end
      end
    end
  end

  // scale by |m|, round half up, sign and saturate
  always_comb begin
    logic [31:0] r;
    for (int i = 0; i < 3; i++) begin
      r = 32'((prod_r[i] + (64'd1 << 30)) >> 31);
      if (r == '0) begin
        j_nxt[i] = '0;
      end else if (c_m1_r.aneg[i] ^ c_m1_r.m[31]) begin
        j_nxt[i] = -$signed(r);
      end else if (r[31]) begin
        j_nxt[i] = 32'sh7FFFFFFF;
      end else begin
        j_nxt[i] = $signed(r);
      end
    end
    if (c_m1_r.degen) begin
      j_nxt[0] = '0;
      j_nxt[1] = '0;
      j_nxt[2] = c_m1_r.m;
    end
  end

  always_comb begin
    logic signed [33:0] sum;
    sum = 34'(j_r[0]) + 34'(j_r[1]) + 34'(j_r[2]);
    if (sum < 0) begin
      ns_nxt = -$signed(c_m2_r.mmag);
    end else if (c_m2_r.mmag[31]) begin
      ns_nxt = 32'sh7FFFFFFF;
    end else begin
      ns_nxt = $signed(c_m2_r.mmag);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= 64'(dvs_r[DVS][i].q) * 64'(car_r[SQS+DVS].mmag);
      end
      c_m1_r <= car_r[SQS+DVS];
      j_r    <= j_nxt;
      c_m2_r <= c_m1_r;
      jx_r   <= j_r[0];
      jy_r   <= j_r[1];
      jz_r   <= j_r[2];
      ns_r   <= ns_nxt;
      dg_r   <= c_m2_r.degen;
    end
  end

  assign out_ch.valid         = v_r[NST-1];
  assign out_ch.jitter_x      = jx_r;
  assign out_ch.jitter_y      = jy_r;
  assign out_ch.jitter_z      = jz_r;
  assign out_ch.normal_scalar = ns_r;
  assign out_ch.degenerate    = dg_r;

  `SRJV_ASSERT_IMPL(a_degen_xy_zero, out_ch.valid && out_ch.degenerate,
    out_ch.jitter_x == 0 && out_ch.jitter_y == 0, "degenerate word with nonzero x or y")
  `SRJV_ASSERT_IMPL(a_root_norm, v_r[ST_SQ_END] && !car_r[SQS].degen,
    sqs_r[SQS].root[31], "square root not normalized")
  `SRJV_ASSERT_IMPL(a_unit_range, v_r[ST_DIV_END] && !car_r[SQS+DVS].degen,
    dvs_r[DVS][0].q <= 32'h80000000 && dvs_r[DVS][1].q <= 32'h80000000 &&
    dvs_r[DVS][2].q <= 32'h80000000, "unit component above one")
  `SRJV_ASSERT_NEXT(a_stall_hold, out_ch.valid && !out_ch.ready, $stable(v_r),
    "pipeline moved during stall")

endmodule

[tb/seeded_random_jitter_vector_top_tb.sv]
// ---------------------------------------------------------------------------
// Seeded random jitter vector testbench
// Drives vertex indices under several seeds with random gaps and output
// stalls, predicts each jitter word in-bench and checks it field by field.
// ---------------------------------------------------------------------------
module seeded_random_jitter_vector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GAP_MAX     = 12;
  localparam int DRAIN_WAIT  = 60;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 150;
  localparam int LONG_STALL  = 600;

  typedef struct {
    logic signed [31:0] jx;
    logic signed [31:0] jy;
    logic signed [31:0] jz;
    logic signed [31:0] ns;
    logic               degen;
  } jitter_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  srjv_in_if  in_ch();
  srjv_out_if out_ch();

  seeded_random_jitter_vector_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  logic [31:0] pending_idx[$];
  jitter_t     expected_jitter[$];
  logic [31:0] seed_shadow;
  int          fail_count;
  int          words_in;
  int          words_out;
  int          degen_seen;
  int          seeds_used;
  int          cycle_count;
  int          send_gap;
  int          recv_gap;
  bit          send_burst;
  bit          recv_burst;
  bit          long_stall_done;

  function automatic longint unsigned splitmix(longint unsigned z);
    z += srjv_pkg::GOLDEN;
    z = (z ^ (z >> 30)) * srjv_pkg::MIX_C1;
    z = (z ^ (z >> 27)) * srjv_pkg::MIX_C2;
    return z ^ (z >> 31);
  endfunction

  function automatic longint hash_q31(longint unsigned h);
    return longint'({32'd0, h[63:32]}) - 64'sd2147483648;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? 64'd0 - longint'(v) : longint'(v);
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint scale_axis(longint a, longint m, longint unsigned len, int s);
    longint unsigned unit_q;
    longint unsigned r;
    unit_q = ((abs64(a) << s) << 31) / len;
    r = (unit_q * abs64(m) + (64'd1 << 30)) >> 31;
    if (r == 0) return 0;
    if ((a < 0) != (m < 0)) return -longint'(r);
    return (r > 64'd2147483647) ? 64'sd2147483647 : longint'(r);
  endfunction

  function automatic jitter_t jitter_of(logic [31:0] seed, logic [31:0] idx);
    longint unsigned base;
    longint          ax, ay, az, m, jx, jy, jz, ns;
    longint unsigned sq, t, len;
    int              s;
    jitter_t         res;
    base = splitmix({seed, 32'd0} ^ {32'd0, idx});
    ax = hash_q31(splitmix(base ^ srjv_pkg::LANE_KEY[0]));
    ay = hash_q31(splitmix(base ^ srjv_pkg::LANE_KEY[1]));
    az = hash_q31(splitmix(base ^ srjv_pkg::LANE_KEY[2]));
    m  = hash_q31(splitmix(base ^ srjv_pkg::LANE_KEY[3]));
    sq = abs64(ax) * abs64(ax) + abs64(ay) * abs64(ay) + abs64(az) * abs64(az);
    if (sq < srjv_pkg::DEGEN_LIMIT) begin
      jx = 0;
      jy = 0;
      jz = m;
      res.degen = 1'b1;
    end else begin
      t = sq;
      s = 0;
      while (t < (64'd1 << 62) && s < 31) begin
        t <<= 2;
        s++;
      end
      len = root64(t);
      jx = scale_axis(ax, m, len, s);
      jy = scale_axis(ay, m, len, s);
      jz = scale_axis(az, m, len, s);
      res.degen = 1'b0;
    end
    if (jx + jy + jz < 0) ns = -longint'(abs64(m));
    else ns = (abs64(m) > 64'd2147483647) ? 64'sd2147483647 : longint'(abs64(m));
    res.jx = jx[31:0];
    res.jy = jy[31:0];
    res.jz = jz[31:0];
    res.ns = ns[31:0];
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid        <= 1'b0;
      in_ch.vertex_index <= '0;
      send_gap           <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_jitter.insert(expected_jitter.size(),
                               jitter_of(seed_shadow, in_ch.vertex_index));
        words_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          in_ch.valid <= 1'b0;
          send_gap    <= send_gap - 1;
        end else if (pending_idx.size() > 0) begin
          in_ch.valid        <= 1'b1;
          in_ch.vertex_index <= pending_idx.pop_front();
          send_gap           <= send_burst ? 0 : $urandom_range(0, GAP_MAX);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    jitter_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        words_out++;
        if (expected_jitter.size() == 0) begin
          $error("unexpected word: jitter_x %0d", out_ch.jitter_x);
          fail_count++;
        end else begin
          e = expected_jitter.pop_front();
          if (out_ch.jitter_x !== e.jx) begin
            $error("jitter_x expected %0d actual %0d", e.jx, out_ch.jitter_x);
            fail_count++;
          end
          if (out_ch.jitter_y !== e.jy) begin
            $error("jitter_y expected %0d actual %0d", e.jy, out_ch.jitter_y);
            fail_count++;
          end
          if (out_ch.jitter_z !== e.jz) begin
            $error("jitter_z expected %0d actual %0d", e.jz, out_ch.jitter_z);
            fail_count++;
          end
          if (out_ch.normal_scalar !== e.ns) begin
            $error("normal_scalar expected %0d actual %0d", e.ns, out_ch.normal_scalar);
            fail_count++;
          end
          if (out_ch.degenerate !== e.degen) begin
            $error("degenerate expected %0b actual %0b", e.degen, out_ch.degenerate);
            fail_count++;
          end
          if (e.degen) degen_seen++;
        end
      end
      if (recv_gap > 0) begin
        out_ch.ready <= 1'b0;
        recv_gap     <= recv_gap - 1;
      end else if (!long_stall_done && words_out >= 300) begin
        // long hold-off so the pipeline fills and backs up the input
        long_stall_done = 1'b1;
        out_ch.ready    <= 1'b0;
        recv_gap        <= LONG_STALL;
      end else if (!out_ch.ready || out_ch.valid) begin
        out_ch.ready <= 1'b1;
        recv_gap     <= recv_burst ? 0 : $urandom_range(0, GAP_MAX);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic drain();
    do begin
      @(negedge clk);
    end while (pending_idx.size() != 0 || in_ch.valid || expected_jitter.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_seed(logic [31:0] v);
    @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= v;
    seed_shadow = v;
    seeds_used++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] seeds[6];
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.vertex_index = '0;
    out_ch.ready       = 1'b0;
    seed_shadow        = '0;
    fail_count         = 0;
    words_in           = 0;
    words_out          = 0;
    degen_seen         = 0;
    seeds_used         = 1;
    cycle_count        = 0;
    send_burst         = 1'b0;
    recv_burst         = 1'b0;
    long_stall_done    = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed indices under the reset seed
    pending_idx = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'hFFFFFFFE, 32'h80000000,
                    32'h7FFFFFFF, 32'h55555555, 32'hAAAAAAAA, 32'h0000FFFF,
                    32'hFFFF0000};
    for (int b = 0; b < 32; b += 4) pending_idx.insert(pending_idx.size(), 32'h1 << b);
    drain();

    seeds = '{32'hFFFFFFFF, 32'h1, 32'h80000000, $urandom, $urandom, 32'h0};
    foreach (seeds[p]) begin
      write_seed(seeds[p]);
      send_burst = ($urandom_range(0, 2) == 0);
      recv_burst = ($urandom_range(0, 2) == 0);
      pending_idx.insert(pending_idx.size(), 32'h0);
      pending_idx.insert(pending_idx.size(), 32'hFFFFFFFF);
      for (int i = 0; i < PHASE_ITEMS + 25; i++) begin
        pending_idx.insert(pending_idx.size(), $urandom);
      end
      drain();
    end

    $display("checked %0d jitter words over %0d seeds (%0d degenerate)",
             words_out, seeds_used, degen_seen);
    $display("sent %0d indices with random gaps, bursts and a long output stall", words_in);
    if (fail_count == 0 && expected_jitter.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
